[src/pfc_pkg.sv]
// Shared types, constants and helper functions for the Playfair digraph cipher block.
package pfc_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_Z = 5'd25;

    typedef enum logic [1:0] {
        MODE_KEY    = 2'd0,
        MODE_FINISH = 2'd1,
        MODE_PAIR   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [4:0] first_letter;
        logic [4:0] second_letter;
    } req_item_t;

    typedef struct packed {
        logic [4:0] first_cipher;
        logic [4:0] second_cipher;
        logic       not_ready;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic walk_step;
        logic key_read;
        logic out_load;
    } pfc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_last;
        logic out_busy;
    } pfc_status_t;

    // Codes above z are treated as z.
    function automatic logic [4:0] clamp_letter(input logic [4:0] l);
        return (l > LETTER_Z) ? LETTER_Z : l;
    endfunction

    // Row of a cell index 0..24, found by compares.
    function automatic logic [2:0] cell_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)
            r = 3'd4;
        else if (p >= 5'd15)
            r = 3'd3;
        else if (p >= 5'd10)
            r = 3'd2;
        else if (p >= 5'd5)
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    // Cell index from row and column: row * 5 + col.
    function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + 5'(r) + 5'(c);
    endfunction

    // Column of a cell index 0..24.
    function automatic logic [2:0] cell_col(input logic [4:0] p);
        logic [4:0] base;
        base = cell_index(cell_row(p), 3'd0);
        return 3'(p - base);
    endfunction

    // Step one place along a row or column, wrapping at the edge.
    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

[src/pfc_ctrl.sv]
// Controller state machine for the Playfair digraph cipher block.
module pfc_ctrl
    import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  mode_t       req_mode,
    input  pfc_status_t status,
    output logic        req_stall,
    output pfc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ENC_POS = 4'b0010,
        ST_ENC_KEY = 4'b0100,
        ST_FINISH  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // One item at a time: take a new item only when idle.
    assign req_stall = (state_reg != ST_IDLE);

    // Command decode and next state.
    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.walk_step = 1'b0;
        cmd.key_read  = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_mode == MODE_PAIR)
                        state_next = ST_ENC_POS;
                    else if (req_mode == MODE_FINISH)
                        state_next = ST_FINISH;
                end
            end
            ST_ENC_POS:
            begin
                cmd.key_read = 1'b1;
                state_next   = ST_ENC_KEY;
            end
            ST_ENC_KEY:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[src/pfc_datapath.sv]
// Datapath of the Playfair digraph cipher block: key table, position map and result register.
module pfc_datapath
    import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_item_t   req,
    input  pfc_cmd_t    cmd,
    input  logic        rsp_stall,
    output pfc_status_t status,
    output logic        rsp_valid,
    output rsp_item_t   rsp
);

    // Letter store and position map; contents are meaningful only once written.
    logic [4:0] key_mem [CELLS];
    logic [4:0] pos_mem [LETTERS];

    logic [LETTERS-1:0] seen_reg, seen_next;
    logic [4:0]         fill_reg, fill_next;
    logic               ready_reg, ready_next;
    logic [4:0]         walk_reg, walk_next;
    logic               nr_reg, nr_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [4:0] pos_a_reg, pos_b_reg;
    logic [4:0] key_a_reg, key_b_reg;
    rsp_item_t  rsp_reg;

    logic [4:0] letter_a, letter_b, enc_a, enc_b;
    logic       place_en;
    logic [4:0] place_letter;
    logic       pos_read;
    logic [2:0] row_a, col_a, row_b, col_b;
    logic [4:0] cell_a, cell_b;

    assign letter_a = clamp_letter(req.first_letter);
    assign letter_b = clamp_letter(req.second_letter);
    assign enc_a    = (letter_a == LETTER_J) ? LETTER_I : letter_a;
    assign enc_b    = (letter_b == LETTER_J) ? LETTER_I : letter_b;
    assign pos_read = cmd.accept && (req.mode == MODE_PAIR);

    // Placement of one letter, from a key item or from one step of the finish walk.
    always_comb
    begin
        place_en     = 1'b0;
        place_letter = walk_reg;
        if (cmd.walk_step)
        begin
            place_en = (walk_reg != LETTER_J) && !seen_reg[walk_reg] && (fill_reg < 5'(CELLS));
        end
        else if (cmd.accept && (req.mode == MODE_KEY))
        begin
            place_letter = letter_a;
            place_en     = !ready_reg && (letter_a != LETTER_J) && !seen_reg[letter_a]
                           && (fill_reg < 5'(CELLS));
        end
    end

    // Table control state.
    always_comb
    begin
        seen_next  = seen_reg;
        fill_next  = fill_reg;
        ready_next = ready_reg;
        walk_next  = walk_reg;
        nr_next    = nr_reg;
        if (place_en)
        begin
            seen_next[place_letter] = 1'b1;
            fill_next               = fill_reg + 5'd1;
        end
        if (cmd.walk_step)
        begin
            walk_next = walk_reg + 5'd1;
            if (status.walk_last)
                ready_next = 1'b1;
        end
        if (cmd.accept)
        begin
            case (req.mode)
                MODE_FINISH:
                    walk_next = 5'd0;
                MODE_CLEAR:
                begin
                    seen_next  = '0;
                    fill_next  = 5'd0;
                    ready_next = 1'b0;
                end
                MODE_PAIR:
                    nr_next = !ready_reg;
                default:
                    nr_next = nr_reg;
            endcase
        end
    end

    assign status.walk_last = (walk_reg == 5'(LETTERS - 1));
    assign status.out_busy  = rsp_valid_reg && rsp_stall;

    // Cipher cells from the two positions: same row, same column, or rectangle.
    always_comb
    begin
        row_a = cell_row(pos_a_reg);
        col_a = cell_col(pos_a_reg);
        row_b = cell_row(pos_b_reg);
        col_b = cell_col(pos_b_reg);
        if (row_a == row_b)
        begin
            cell_a = cell_index(row_a, wrap_inc(col_a));
            cell_b = cell_index(row_b, wrap_inc(col_b));
        end
        else if (col_a == col_b)
        begin
            cell_a = cell_index(wrap_inc(row_a), col_a);
            cell_b = cell_index(wrap_inc(row_b), col_b);
        end
        else
        begin
            cell_a = cell_index(row_a, col_b);
            cell_b = cell_index(row_b, col_a);
        end
    end

    // Result register, freed when the item is taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (cmd.out_load)
            rsp_valid_next = 1'b1;
    end

    // Memories: one write port, two registered read ports each.
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            key_mem[fill_reg]     <= place_letter;
            pos_mem[place_letter] <= fill_reg;
        end
        if (pos_read)
        begin
            pos_a_reg <= pos_mem[enc_a];
            pos_b_reg <= pos_mem[enc_b];
        end
        if (cmd.key_read)
        begin
            key_a_reg <= key_mem[cell_a];
            key_b_reg <= key_mem[cell_b];
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.not_ready     <= nr_reg;
            rsp_reg.first_cipher  <= nr_reg ? 5'd0 : key_a_reg;
            rsp_reg.second_cipher <= nr_reg ? 5'd0 : key_b_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            fill_reg      <= 5'd0;
            ready_reg     <= 1'b0;
            walk_reg      <= 5'd0;
            nr_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            fill_reg      <= fill_next;
            ready_reg     <= ready_next;
            walk_reg      <= walk_next;
            nr_reg        <= nr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every filled cell holds exactly one distinct seen letter.
    a_fill_matches_seen: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(seen_reg) == 32'(fill_reg))
        else $error("fill count does not match seen letters");

    // A finished table is full.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (fill_reg == 5'(CELLS)))
        else $error("table ready but not full");

    // A result is never loaded over one that is still held.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(rsp_valid_reg && rsp_stall))
        else $error("result overwritten while stalled");

    // A not-ready result carries zero letters.
    a_nr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.not_ready) |->
            (rsp_reg.first_cipher == 5'd0 && rsp_reg.second_cipher == 5'd0))
        else $error("not-ready result with nonzero letters");

endmodule

[src/playfair_digraph_cipher_top.sv]
// One item at a time: key letter and clear items are done when they are accepted.
// An encrypt item goes through position map read, key table read and result
// load, in that order; the result load waits while the held result stalls.
// A finish item is acceptance plus one step per letter a..z.
// Reset (rst_n, asynchronous, active low) empties the table and clears the
// result; the key table memories themselves are not cleared.
module playfair_digraph_cipher_top
    import pfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    pfc_cmd_t    cmd;
    pfc_status_t status;

    // Sequencer.
    pfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req.mode),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    // Tables and cipher logic.
    pfc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
